FILE: rtl/chbd_pkg.sv
package chbd_pkg;

  localparam int CFG_W = 24;
  localparam int ACC_W = 25;

  localparam logic [ACC_W-1:0] ACC_SAT = 25'h100_0000;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LINE_LEN = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX  = 3'd2;
  localparam logic [2:0] ERR_LIMIT    = 3'd3;
  localparam logic [2:0] ERR_NO_CRLF  = 3'd4;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X_LO  = 8'h78;
  localparam logic [7:0] CHAR_X_UP  = 8'h58;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       begin_req;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
  } result_t;

  // classified byte handed from the front to the back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       begin_req;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_blank;
    logic       is_zero;
    logic       is_x;
    logic       is_cr;
    logic       is_lf;
  } byte_class_t;

endpackage

FILE: rtl/chbd_queue.sv
module chbd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  logic do_wr;
  logic do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + CW'(1)))
    else $error("queue count did not grow on write");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

FILE: rtl/chbd_front.sv
module chbd_front
  import chbd_pkg::*;
(
  input  logic        push,
  input  in_item_t    item,
  input  logic        q_full,
  output logic        q_wr,
  output byte_class_t cls
);

  logic [7:0] c;

  assign c    = item.data_byte;
  assign q_wr = push && !q_full;

  always_comb begin
    cls           = '0;
    cls.data_byte = c;
    cls.begin_req = item.begin_req;
    cls.is_blank  = (c == CHAR_SPACE) || (c == CHAR_TAB);
    cls.is_zero   = (c == CHAR_ZERO);
    cls.is_x      = (c == CHAR_X_LO) || (c == CHAR_X_UP);
    cls.is_cr     = (c == CHAR_CR);
    cls.is_lf     = (c == CHAR_LF);
    if (c >= 8'h30 && c <= 8'h39) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // 'a'..'f' and 'A'..'F' share the low nibble 1..6
      cls.is_hex  = 1'b1;
      cls.hex_val = c[3:0] + 4'd9;
    end
  end

endmodule

FILE: rtl/chbd_back.sv
module chbd_back
  import chbd_pkg::*;
#(
  parameter int SIZE_LINE_LIMIT = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cls_valid,
  input  byte_class_t      cls,
  output logic             take,
  input  logic             res_room,
  output logic             res_valid,
  output result_t          res,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int LW = $clog2(SIZE_LINE_LIMIT + 1);

  localparam logic [3:0] PH_LEAD    = 4'd0;
  localparam logic [3:0] PH_ZERO    = 4'd1;
  localparam logic [3:0] PH_DIGITS  = 4'd2;
  localparam logic [3:0] PH_TAIL    = 4'd3;
  localparam logic [3:0] PH_DATA    = 4'd4;
  localparam logic [3:0] PH_DATA_CR = 4'd5;
  localparam logic [3:0] PH_DATA_LF = 4'd6;
  localparam logic [3:0] PH_END_CR  = 4'd7;
  localparam logic [3:0] PH_END_LF  = 4'd8;
  localparam logic [3:0] PH_DONE    = 4'd9;
  localparam logic [3:0] PH_ERROR   = 4'd10;

  logic [CFG_W-1:0] max_body_bytes;

  logic [3:0]       phase;
  logic [ACC_W-1:0] size_acc;
  logic [CFG_W-1:0] bytes_left;
  logic [ACC_W-1:0] total_bytes;
  logic [LW-1:0]    line_length;
  logic             digit_seen;
  logic             prev_cr;

  logic [3:0]       phase_next;
  logic [ACC_W-1:0] size_acc_next;
  logic [CFG_W-1:0] bytes_left_next;
  logic [ACC_W-1:0] total_bytes_next;
  logic [LW-1:0]    line_length_next;
  logic             digit_seen_next;
  logic             prev_cr_next;

  // state as seen by this byte, after an optional begin_req clear
  logic [3:0]       cur_phase;
  logic [ACC_W-1:0] cur_acc;
  logic [CFG_W-1:0] cur_left;
  logic [ACC_W-1:0] cur_total;
  logic [LW-1:0]    cur_line;
  logic             cur_digit;
  logic             cur_cr;

  logic [ACC_W-1:0] acc_dig;
  logic [ACC_W:0]   sum_total;
  logic             over_limit;
  logic [CFG_W-1:0] left_dec;

  assign take = cls_valid && res_room;

  assign cur_phase = cls.begin_req ? PH_LEAD : phase;
  assign cur_acc   = cls.begin_req ? '0 : size_acc;
  assign cur_left  = cls.begin_req ? '0 : bytes_left;
  assign cur_total = cls.begin_req ? '0 : total_bytes;
  assign cur_line  = cls.begin_req ? '0 : line_length;
  assign cur_digit = cls.begin_req ? 1'b0 : digit_seen;
  assign cur_cr    = cls.begin_req ? 1'b0 : prev_cr;

  // saturate once another digit could pass 2^24
  assign acc_dig    = (cur_acc[ACC_W-1:20] != '0) ? ACC_SAT : {cur_acc[20:0], cls.hex_val};
  assign sum_total  = {1'b0, cur_total} + {1'b0, cur_acc};
  assign over_limit = (cur_acc > {1'b0, max_body_bytes}) ||
                      (sum_total > {2'b0, max_body_bytes});
  assign left_dec   = cur_left - CFG_W'(1);

  always_comb begin
    phase_next       = cur_phase;
    size_acc_next    = cur_acc;
    bytes_left_next  = cur_left;
    total_bytes_next = cur_total;
    line_length_next = cur_line;
    digit_seen_next  = cur_digit;
    prev_cr_next     = cur_cr;
    res_valid        = 1'b0;
    res              = '0;

    unique case (cur_phase) inside
      PH_LEAD, PH_ZERO, PH_DIGITS, PH_TAIL: begin
        if (cur_line >= LW'(SIZE_LINE_LIMIT)) begin
          phase_next     = PH_ERROR;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_LINE_LEN;
        end else begin
          line_length_next = cur_line + LW'(1);
          if (cls.is_lf && cur_cr) begin
            prev_cr_next = 1'b0;
            if (!cur_digit) begin
              phase_next     = PH_ERROR;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_BAD_HEX;
            end else if (over_limit) begin
              phase_next     = PH_ERROR;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_LIMIT;
            end else if (cur_acc == '0) begin
              phase_next = PH_END_CR;
            end else begin
              total_bytes_next = sum_total[ACC_W-1:0];
              bytes_left_next  = cur_acc[CFG_W-1:0];
              phase_next       = PH_DATA;
            end
          end else begin
            prev_cr_next = cls.is_cr;
            if (cur_phase == PH_LEAD) begin
              if (cls.is_blank) begin
                phase_next = PH_LEAD;
              end else if (cls.is_zero) begin
                digit_seen_next = 1'b1;
                phase_next      = PH_ZERO;
              end else if (cls.is_hex) begin
                size_acc_next   = acc_dig;
                digit_seen_next = 1'b1;
                phase_next      = PH_DIGITS;
              end else begin
                phase_next = PH_TAIL;
              end
            end else if (cur_phase == PH_ZERO) begin
              if (cls.is_x) begin
                phase_next = PH_DIGITS;
              end else if (cls.is_hex) begin
                size_acc_next   = acc_dig;
                digit_seen_next = 1'b1;
                phase_next      = PH_DIGITS;
              end else begin
                phase_next = PH_TAIL;
              end
            end else if (cur_phase == PH_DIGITS) begin
              if (cls.is_hex) begin
                size_acc_next   = acc_dig;
                digit_seen_next = 1'b1;
              end else begin
                phase_next = PH_TAIL;
              end
            end
          end
        end
      end
      PH_DATA: begin
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          phase_next = PH_DATA_CR;
        end
        res_valid    = 1'b1;
        res.out_byte = cls.data_byte;
        res.kind     = KIND_PAYLOAD;
      end
      PH_DATA_CR, PH_END_CR: begin
        if (!cls.is_cr) begin
          phase_next     = PH_ERROR;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_NO_CRLF;
        end else begin
          phase_next = (cur_phase == PH_DATA_CR) ? PH_DATA_LF : PH_END_LF;
        end
      end
      PH_DATA_LF: begin
        if (!cls.is_lf) begin
          phase_next     = PH_ERROR;
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_NO_CRLF;
        end else begin
          phase_next       = PH_LEAD;
          size_acc_next    = '0;
          line_length_next = '0;
          digit_seen_next  = 1'b0;
          prev_cr_next     = 1'b0;
        end
      end
      PH_END_LF: begin
        res_valid = 1'b1;
        if (!cls.is_lf) begin
          phase_next     = PH_ERROR;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_NO_CRLF;
        end else begin
          phase_next = PH_DONE;
          res.kind   = KIND_DONE;
        end
      end
      default: begin
        // done or error: swallow bytes until begin_req
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= CFG_W'(1048576);
    end else if (cfg_valid) begin
      max_body_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      size_acc    <= '0;
      bytes_left  <= '0;
      total_bytes <= '0;
      line_length <= '0;
      digit_seen  <= 1'b0;
      prev_cr     <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      size_acc    <= size_acc_next;
      bytes_left  <= bytes_left_next;
      total_bytes <= total_bytes_next;
      line_length <= line_length_next;
      digit_seen  <= digit_seen_next;
      prev_cr     <= prev_cr_next;
    end
  end

  a_err_has_code: assert property (@(posedge clk) disable iff (rst)
    (take && res_valid && res.kind == KIND_ERROR) |-> (res.error_code != ERR_NONE))
    else $error("error result without a code");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERROR && !(take && cls.begin_req)) |=> (phase == PH_ERROR))
    else $error("left error phase without begin_req");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (take && !cls.begin_req && (phase == PH_DONE || phase == PH_ERROR)) |-> !res_valid)
    else $error("result after body end");

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_left != '0))
    else $error("data phase with no bytes left");

endmodule

FILE: rtl/http_chunked_body_decoder.sv
// Chunked HTTP body decoder, one raw body byte per request.
// Input channel: push/full. A request is taken at a clock edge with push high
// and full low; it carries data_byte and begin_req (begin_req clears the
// decoder before that byte, starting a new body).
// Result channel: empty/pop. While empty is low the oldest result sits on
// result; pop with empty low takes it. A result is a payload byte, a body
// complete mark, or an error with its code; size-line, CR LF bytes and
// everything after the end or an error produce no result.
// Config channel: cfg_valid/cfg_ready, always ready; cfg_data sets
// max_body_bytes (reset value 1048576). Write it only while idle.
// Throughput: one byte per cycle sustained while the result queue has room;
// the decode state machine in the back end handles one byte per cycle when
// it takes one. A byte is held in the byte queue, its result in the result queue.
// Reset (rst, synchronous) empties both queues and returns to the start of a
// size line. When the receiver stops popping, the result queue fills, the
// back end stops, then the byte queue fills and full rises; nothing is lost.
module http_chunked_body_decoder
  import chbd_pkg::*;
#(
  parameter int SIZE_LINE_LIMIT = 1024,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  in_item_t         item,
  output logic             empty,
  input  logic             pop,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  byte_class_t cls_in;
  byte_class_t cls_out;
  logic        q_wr;
  logic        mid_empty;
  logic        take;
  logic        out_full;
  logic        res_valid;
  result_t     res;

  assign cfg_ready = 1'b1;

  chbd_front u_front (
    .push   (push),
    .item   (item),
    .q_full (full),
    .q_wr   (q_wr),
    .cls    (cls_in)
  );

  chbd_queue #(
    .WIDTH ($bits(byte_class_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (cls_in),
    .full  (full),
    .rd    (take),
    .rdata (cls_out),
    .empty (mid_empty)
  );

  chbd_back #(
    .SIZE_LINE_LIMIT (SIZE_LINE_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (!mid_empty),
    .cls       (cls_out),
    .take      (take),
    .res_room  (!out_full),
    .res_valid (res_valid),
    .res       (res),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data)
  );

  chbd_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (take && res_valid),
    .wdata (res),
    .full  (out_full),
    .rd    (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule
